### design/lzssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_pkg
// shared constants and types of the lzss window decompressor
// ----------------------------------------------------------------------------
package lzssd_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int ADDR_W      = $clog2(WINDOW_SIZE);
    localparam int LEN_W       = 5;
    localparam int LEN_BIAS    = 2;
    localparam int MAX_LEN     = 17;

    // window access request from the parser to the history memory
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // one decoded result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       stream_done;
    } result_t;

endpackage

### design/lzssd_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_window
// history window ram, one write and one registered read per cycle, cleared
// to zero by a sweep after reset
// ----------------------------------------------------------------------------
module lzssd_window (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lzssd_pkg::mem_req_t               mem_req,
    output logic [7:0]                        rd_data,
    output logic                              clearing
);

    logic [7:0]                     mem [lzssd_pkg::WINDOW_SIZE];
    logic [7:0]                     rd_data_reg;
    logic                           clearing_reg;
    logic                           clearing_next;
    logic [lzssd_pkg::ADDR_W-1:0]   clr_addr_reg;
    logic [lzssd_pkg::ADDR_W-1:0]   clr_addr_next;
    logic                           we;
    logic [lzssd_pkg::ADDR_W-1:0]   waddr;
    logic [7:0]                     wdata;

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

    // clear sweep owns the write port until it finishes
    always_comb begin
        we            = clearing_reg ? 1'b1 : mem_req.wr_en;
        waddr         = clearing_reg ? clr_addr_reg : mem_req.wr_addr;
        wdata         = clearing_reg ? 8'h00 : mem_req.wr_data;
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + lzssd_pkg::ADDR_W'(1);
            if (clr_addr_reg == {lzssd_pkg::ADDR_W{1'b1}}) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (mem_req.rd_en) begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

endmodule

### design/lzssd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_ctrl
// token parser and back-reference copy sequencer around the history ram
// ----------------------------------------------------------------------------
module lzssd_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tlast,
    output logic                              s_tready,
    input  logic                              out_ready,
    input  logic                              clearing,
    input  logic [7:0]                        rd_data,
    output lzssd_pkg::mem_req_t               mem_req,
    output logic                              res_valid,
    output lzssd_pkg::result_t                res
);

    localparam logic [1:0] PH_TAG  = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_PAIR = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]                    phase_reg, phase_next;
    logic [7:0]                    flag_byte_reg, flag_byte_next;
    logic [2:0]                    flag_pos_reg, flag_pos_next;
    logic [7:0]                    pair_first_reg, pair_first_next;
    logic [lzssd_pkg::ADDR_W-1:0]  wr_idx_reg, wr_idx_next;
    logic                          last_pend_reg, last_pend_next;
    logic [lzssd_pkg::ADDR_W-1:0]  src_reg, src_next;
    logic [lzssd_pkg::LEN_W-1:0]   cnt_reg, cnt_next;
    logic                          d_valid_reg, d_valid_next;
    logic                          d_last_reg, d_last_next;
    logic                          fwd_reg, fwd_next;
    logic [7:0]                    fwd_data_reg, fwd_data_next;

    logic                          busy;
    logic                          in_fire;
    logic                          cur_flag;
    logic [lzssd_pkg::ADDR_W-1:0]  pair_offset;
    logic [lzssd_pkg::LEN_W-1:0]   pair_len;
    logic                          is_lit;
    logic                          is_end;
    logic                          copy_start;
    logic                          copy_emit;
    logic [7:0]                    copy_byte;
    logic                          issue;

    always_comb begin
        busy        = (cnt_reg != '0) || d_valid_reg;
        s_tready    = !clearing && !busy && out_ready;
        in_fire     = s_tvalid && s_tready;
        cur_flag    = flag_byte_reg[flag_pos_reg];
        pair_offset = {s_tdata, pair_first_reg[7:4]};
        pair_len    = {1'b0, pair_first_reg[3:0]} + lzssd_pkg::LEN_W'(lzssd_pkg::LEN_BIAS);
        is_lit      = in_fire && (phase_reg == PH_DATA) && !cur_flag;
        is_end      = in_fire && (phase_reg == PH_PAIR) && (pair_offset == '0);
        copy_start  = in_fire && (phase_reg == PH_PAIR) && (pair_offset != '0);
        copy_emit   = d_valid_reg && out_ready;
        copy_byte   = fwd_reg ? fwd_data_reg : rd_data;
        issue       = (cnt_reg != '0) && (!d_valid_reg || out_ready);

        mem_req.wr_en   = copy_emit || is_lit;
        mem_req.wr_addr = wr_idx_reg;
        mem_req.wr_data = copy_emit ? copy_byte : s_tdata;
        mem_req.rd_en   = issue;
        mem_req.rd_addr = src_reg;

        res_valid       = copy_emit || is_lit || is_end;
        res.out_byte    = copy_emit ? copy_byte : (is_lit ? s_tdata : 8'h00);
        res.has_byte    = copy_emit || is_lit;
        res.run_last    = copy_emit ? d_last_reg : 1'b1;
        res.stream_done = is_end;
    end

    always_comb begin
        phase_next      = phase_reg;
        flag_byte_next  = flag_byte_reg;
        flag_pos_next   = flag_pos_reg;
        pair_first_next = pair_first_reg;
        wr_idx_next     = wr_idx_reg;
        last_pend_next  = last_pend_reg;
        src_next        = src_reg;
        cnt_next        = cnt_reg;
        d_valid_next    = d_valid_reg;
        d_last_next     = d_last_reg;
        fwd_next        = fwd_reg;
        fwd_data_next   = fwd_data_reg;

        if (in_fire) begin
            case (phase_reg)
                PH_TAG: begin
                    flag_byte_next = s_tdata;
                    flag_pos_next  = 3'd0;
                    phase_next     = PH_DATA;
                end
                PH_DATA: begin
                    if (cur_flag) begin
                        pair_first_next = s_tdata;
                        phase_next      = PH_PAIR;
                    end else begin
                        wr_idx_next   = wr_idx_reg + lzssd_pkg::ADDR_W'(1);
                        flag_pos_next = flag_pos_reg + 3'd1;
                        phase_next    = (flag_pos_reg == 3'd7) ? PH_TAG : PH_DATA;
                    end
                end
                PH_PAIR: begin
                    if (pair_offset == '0) begin
                        phase_next = PH_DONE;
                    end else begin
                        src_next       = pair_offset;
                        cnt_next       = pair_len;
                        last_pend_next = s_tlast;
                        flag_pos_next  = flag_pos_reg + 3'd1;
                        phase_next     = (flag_pos_reg == 3'd7) ? PH_TAG : PH_DATA;
                    end
                end
                default: begin
                end
            endcase
            // end of stream: back to tag, write index restarts (after any copy)
            if (s_tlast) begin
                phase_next    = PH_TAG;
                flag_pos_next = 3'd0;
                if (!copy_start) begin
                    wr_idx_next = lzssd_pkg::ADDR_W'(1);
                end
            end
        end

        if (issue) begin
            src_next      = src_reg + lzssd_pkg::ADDR_W'(1);
            cnt_next      = cnt_reg - lzssd_pkg::LEN_W'(1);
            d_valid_next  = 1'b1;
            d_last_next   = (cnt_reg == lzssd_pkg::LEN_W'(1));
            // read and write of the same entry in one cycle: take the new byte
            fwd_next      = mem_req.wr_en && (mem_req.wr_addr == src_reg);
            fwd_data_next = mem_req.wr_data;
        end else if (copy_emit) begin
            d_valid_next = 1'b0;
        end

        if (copy_emit) begin
            wr_idx_next = (d_last_reg && last_pend_reg) ? lzssd_pkg::ADDR_W'(1)
                                                        : wr_idx_reg + lzssd_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TAG;
            flag_pos_reg  <= 3'd0;
            wr_idx_reg    <= lzssd_pkg::ADDR_W'(1);
            last_pend_reg <= 1'b0;
            cnt_reg       <= '0;
            d_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            flag_pos_reg  <= flag_pos_next;
            wr_idx_reg    <= wr_idx_next;
            last_pend_reg <= last_pend_next;
            cnt_reg       <= cnt_next;
            d_valid_reg   <= d_valid_next;
            fwd_reg       <= fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        flag_byte_reg  <= flag_byte_next;
        pair_first_reg <= pair_first_next;
        src_reg        <= src_next;
        d_last_reg     <= d_last_next;
        fwd_data_reg   <= fwd_data_next;
    end

`ifndef SYNTHESIS
    a_res_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_ready)
        else $error("result produced while output register is full");

    a_issue_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> d_valid_reg)
        else $error("window read issued but data stage empty");

    a_stall_holds_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg && !out_ready |=> d_valid_reg && $stable(d_last_reg))
        else $error("copy byte lost under output stall");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= lzssd_pkg::LEN_W'(lzssd_pkg::MAX_LEN))
        else $error("copy count out of range");
`endif

endmodule

### design/lzss_window_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decompressor
// lzss decoder with a 4096-byte history window
// ----------------------------------------------------------------------------
// usage
//  - slave channel: one compressed byte per transaction (tag, literal or
//    pair byte), s_tlast marks the final byte of a stream
//  - master channel: one decoded byte per transaction; m_tuser[0] set when
//    m_tdata holds a byte, m_tuser[1] flags the end marker status result,
//    m_tlast marks the final result caused by one input byte
//  - tag and first pair bytes give no result; a literal's byte is in the
//    output register the next cycle
//  - a back reference has length 2 to 17: the copy streams one byte per
//    cycle through the window ram while the receiver does not stall (one
//    read, one write per cycle, read data registered)
//  - reset: the window ram is swept to zero across all 4096 entries, s_tready
//    stays low until the sweep is done; write index restarts at 1
//  - receiver stall: the output register holds its transaction, the copy
//    pauses with its read byte held, and no new input is taken
// ----------------------------------------------------------------------------
module lzss_window_decompressor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [0] has_byte, [1] stream_done
    output logic        m_tlast    // run_last
);

    lzssd_pkg::mem_req_t  mem_req;
    lzssd_pkg::result_t   res;
    logic                 res_valid;
    logic [7:0]           rd_data;
    logic                 clearing;
    logic                 out_ready;

    // output register
    logic                 m_valid_reg, m_valid_next;
    lzssd_pkg::result_t   m_res_reg, m_res_next;

    assign out_ready = !m_valid_reg || m_tready;

    lzssd_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    lzssd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .out_ready (out_ready),
        .clearing  (clearing),
        .rd_data   (rd_data),
        .mem_req   (mem_req),
        .res_valid (res_valid),
        .res       (res)
    );

    // load on a new result, drop once the receiver takes the transaction
    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.out_byte;
    assign m_tuser  = {m_res_reg.stream_done, m_res_reg.has_byte};
    assign m_tlast  = m_res_reg.run_last;

endmodule

### bench/lzss_window_decompressor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_window_decompressor_test
// self-checking bench for the lzss window decompressor
// ----------------------------------------------------------------------------
// feeds compressed byte streams through the slave channel and checks every
// master transaction against a cycle-free decoder model kept in the bench, or
// against a row's hand-typed expectation. a short table of hand-built streams
// comes first (extremes, overlapping copy, end marker, ignored tail, streams
// cut on a tag, a literal or inside a pair), then random well-formed streams
// mixed with noise. both channels idle at random, with one long quiet stretch.
// ----------------------------------------------------------------------------
module lzss_window_decompressor_test;

    localparam int RANDOM_BYTES = 500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT     = 8;

    typedef enum logic [1:0] {
        EXPECT_TAG,
        EXPECT_DATA,
        EXPECT_PAIR_HI,
        SKIP_TO_LAST
    } parse_phase_t;

    // one compressed byte plus an optional hand-typed expectation
    typedef struct packed {
        logic [7:0] din;
        logic       dlast;
        logic       typed;
        logic [4:0] count;
        logic [7:0] obyte;
        logic       ohas;
        logic       odone;
    } stim_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    lzss_window_decompressor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // decoder model state
    logic [7:0]                   window_copy [lzssd_pkg::WINDOW_SIZE];
    logic [lzssd_pkg::ADDR_W-1:0] copy_wr_idx;
    logic [7:0]                   copy_flags;
    logic [2:0]                   copy_flag_pos;
    parse_phase_t                 copy_phase;
    logic [7:0]                   copy_pair_b0;

    lzssd_pkg::result_t decoded_q [$];
    lzssd_pkg::result_t pending_results [$];
    stim_row_t          cur_row;
    stim_row_t          directed_rows [0:25];

    bit                           idle_ok = 1'b1;
    logic [lzssd_pkg::ADDR_W-1:0] gen_pos;
    int                           bytes_sent;
    int                           bytes_accepted;
    int                           results_checked;
    int                           copies_seen;
    int                           markers_seen;
    int                           mismatches;
    int                           cycles;

    always #4 aclk = ~aclk;

    // receiver side stalls
    always @(negedge aclk) begin
        m_tready <= !(idle_ok && $urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("** lzss_window_decompressor: FAILED **");
            $finish;
        end
    end

    task automatic clear_model();
        int i;
        for (i = 0; i < lzssd_pkg::WINDOW_SIZE; i++) window_copy[i] = 8'h00;
        copy_wr_idx   = lzssd_pkg::ADDR_W'(1);
        copy_flags    = 8'h00;
        copy_flag_pos = 3'd0;
        copy_phase    = EXPECT_TAG;
        copy_pair_b0  = 8'h00;
    endtask

    task automatic step_flag();
        if (copy_flag_pos == 3'd7) begin
            copy_flag_pos = 3'd0;
            copy_phase    = EXPECT_TAG;
        end else begin
            copy_flag_pos = copy_flag_pos + 3'd1;
            copy_phase    = EXPECT_DATA;
        end
    endtask

    // decodes one compressed byte into decoded_q
    task automatic decode_byte(input logic [7:0] b, input logic lst);
        logic [lzssd_pkg::ADDR_W-1:0] src;
        int                           len;
        int                           i;
        lzssd_pkg::result_t           r;
        decoded_q.delete();
        case (copy_phase)
            EXPECT_TAG: begin
                copy_flags    = b;
                copy_flag_pos = 3'd0;
                copy_phase    = EXPECT_DATA;
            end
            EXPECT_DATA: begin
                if (!copy_flags[copy_flag_pos]) begin
                    window_copy[copy_wr_idx] = b;
                    copy_wr_idx = copy_wr_idx + lzssd_pkg::ADDR_W'(1);
                    r = '{out_byte: b, has_byte: 1'b1, run_last: 1'b1,
                          stream_done: 1'b0};
                    decoded_q.push_back(r);
                    step_flag();
                end else begin
                    copy_pair_b0 = b;
                    copy_phase   = EXPECT_PAIR_HI;
                end
            end
            EXPECT_PAIR_HI: begin
                src = {b, copy_pair_b0[7:4]};
                len = int'(copy_pair_b0[3:0]) + lzssd_pkg::LEN_BIAS;
                if (src == '0) begin
                    r = '{out_byte: 8'h00, has_byte: 1'b0, run_last: 1'b1,
                          stream_done: 1'b1};
                    decoded_q.push_back(r);
                    markers_seen++;
                    copy_phase = SKIP_TO_LAST;
                end else begin
                    // byte by byte, so an overlapping copy rereads its own output
                    for (i = 0; i < len; i++) begin
                        r.out_byte    = window_copy[src];
                        r.has_byte    = 1'b1;
                        r.run_last    = (i == len - 1);
                        r.stream_done = 1'b0;
                        window_copy[copy_wr_idx] = r.out_byte;
                        copy_wr_idx = copy_wr_idx + lzssd_pkg::ADDR_W'(1);
                        src = src + lzssd_pkg::ADDR_W'(1);
                        decoded_q.push_back(r);
                    end
                    copies_seen++;
                    step_flag();
                end
            end
            default: ;
        endcase
        if (lst) begin
            copy_phase    = EXPECT_TAG;
            copy_flag_pos = 3'd0;
            copy_wr_idx   = lzssd_pkg::ADDR_W'(1);
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge aclk) begin : monitor
        lzssd_pkg::result_t want;
        int                 k;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %h user %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.out_byte || m_tuser[0] !== want.has_byte ||
                        m_tuser[1] !== want.stream_done || m_tlast !== want.run_last) begin
                        mismatches++;
                        $display({"%0t: mismatch, expected byte %h has %b done %b last %b,",
                                  " got byte %h has %b done %b last %b"},
                                 $time, want.out_byte, want.has_byte, want.stream_done,
                                 want.run_last, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                bytes_accepted++;
                decode_byte(s_tdata, s_tlast);
                if (cur_row.typed) begin
                    for (k = 0; k < int'(cur_row.count); k++) begin
                        want.out_byte    = cur_row.obyte;
                        want.has_byte    = cur_row.ohas;
                        want.stream_done = cur_row.odone;
                        want.run_last    = (k == int'(cur_row.count) - 1);
                        pending_results.push_back(want);
                    end
                end else begin
                    for (k = 0; k < decoded_q.size(); k++) begin
                        pending_results.push_back(decoded_q[k]);
                    end
                end
            end
        end
    end

    function automatic stim_row_t plain(input logic [7:0] b, input logic lst);
        stim_row_t row;
        row       = '0;
        row.din   = b;
        row.dlast = lst;
        return row;
    endfunction

    // one slave transaction, with random gaps in front
    task automatic send_byte(input stim_row_t row);
        @(negedge aclk);
        while (idle_ok && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.din;
        s_tlast  <= row.dlast;
        cur_row   = row;
        bytes_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // a back reference, mostly close behind the write position
    task automatic send_copy(input logic lst);
        logic [lzssd_pkg::ADDR_W-1:0] ofs;
        logic [3:0]                   len_code;
        int                           len;
        len = ($urandom_range(0, 4) == 0) ? lzssd_pkg::MAX_LEN
                                          : $urandom_range(lzssd_pkg::LEN_BIAS,
                                                           lzssd_pkg::MAX_LEN);
        if ($urandom_range(0, 9) < 6)
            ofs = lzssd_pkg::ADDR_W'(gen_pos - 1 - $urandom_range(0, 31));
        else
            ofs = lzssd_pkg::ADDR_W'($urandom_range(1, lzssd_pkg::WINDOW_SIZE - 1));
        if (ofs == '0) ofs = lzssd_pkg::ADDR_W'(1);
        len_code = 4'(len - lzssd_pkg::LEN_BIAS);
        send_byte(plain({ofs[3:0], len_code}, 1'b0));
        send_byte(plain(ofs[11:4], lst));
        gen_pos = gen_pos + lzssd_pkg::ADDR_W'(len);
    endtask

    task automatic send_stream();
        logic [7:0] tag;
        int         groups;
        int         ending;
        int         tail;
        int         g;
        int         f;
        gen_pos = lzssd_pkg::ADDR_W'(1);
        groups  = $urandom_range(1, 4);
        ending  = $urandom_range(0, 9);
        for (g = 0; g < groups; g++) begin
            tag = 8'($urandom);
            send_byte(plain(tag, 1'b0));
            for (f = 0; f < 8; f++) begin
                if (!tag[f]) begin
                    send_byte(plain(8'($urandom), 1'b0));
                    gen_pos = gen_pos + lzssd_pkg::ADDR_W'(1);
                end else begin
                    send_copy(1'b0);
                end
            end
        end
        if (ending < 6) begin
            // end marker, then a few ignored bytes up to the last one
            tail = $urandom_range(0, 3);
            send_byte(plain(8'($urandom) | 8'h01, 1'b0));
            send_byte(plain({4'h0, 4'($urandom)}, 1'b0));
            send_byte(plain(8'h00, tail == 0));
            for (f = 0; f < tail; f++) send_byte(plain(8'($urandom), f == tail - 1));
        end else if (ending < 8) begin
            // cut inside a pair
            send_byte(plain(8'($urandom) | 8'h01, 1'b0));
            send_byte(plain(8'($urandom), 1'b1));
        end else if (ending == 8) begin
            send_byte(plain(8'($urandom) & 8'hFE, 1'b0));
            send_byte(plain(8'($urandom), 1'b1));
        end else begin
            send_byte(plain(8'($urandom) | 8'h01, 1'b0));
            send_copy(1'b1);
        end
    endtask

    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) send_byte(plain(8'($urandom), i == n - 1));
    endtask

    initial begin : stimulus
        int i;
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        m_tready = 1'b1;
        cur_row  = '0;
        clear_model();

        // din, last, typed, count, byte, has, done
        directed_rows = '{
            '{8'h0A, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0}, // tag: lit, pair, lit, pair, 4 lits
            '{8'h00, 1'b0, 1'b1, 5'd1,  8'h00, 1'b1, 1'b0}, // literal, lowest value
            '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0}, // pair, longest length
            '{8'hFF, 1'b0, 1'b1, 5'd17, 8'h00, 1'b1, 1'b0}, // top offset wraps into zeroed window
            '{8'hFF, 1'b0, 1'b1, 5'd1,  8'hFF, 1'b1, 1'b0}, // literal, highest value
            '{8'h33, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0, 1'b0}, // copy from one behind: overlapping
            '{8'h01, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0, 1'b0},
            '{8'h80, 1'b0, 1'b1, 5'd1,  8'h80, 1'b1, 1'b0},
            '{8'h01, 1'b0, 1'b1, 5'd1,  8'h01, 1'b1, 1'b0},
            '{8'h7F, 1'b0, 1'b1, 5'd1,  8'h7F, 1'b1, 1'b0},
            '{8'hFE, 1'b0, 1'b1, 5'd1,  8'hFE, 1'b1, 1'b0}, // eighth flag used up
            '{8'h01, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0}, // new tag
            '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0},
            '{8'h00, 1'b0, 1'b1, 5'd1,  8'h00, 1'b0, 1'b1}, // end marker status
            '{8'h55, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0}, // ignored after marker
            '{8'hAA, 1'b1, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0}, // ignored, closes the stream
            '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0}, // second stream, window kept
            '{8'h10, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0, 1'b0},
            '{8'h00, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0, 1'b0}, // offset one, shortest length
            '{8'h21, 1'b1, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0}, // stream cut inside a pair
            '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0},
            '{8'h3C, 1'b1, 1'b1, 5'd1,  8'h3C, 1'b1, 1'b0}, // stream ends on a literal
            '{8'h55, 1'b1, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0}, // stream ends on its tag
            '{8'h01, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0},
            '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0, 1'b0},
            '{8'h00, 1'b1, 1'b1, 5'd1,  8'h00, 1'b0, 1'b1}  // end marker on the last byte
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < $size(directed_rows); i++) send_byte(directed_rows[i]);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            // quiet stretch: no idling on either channel
            idle_ok = !(bytes_sent >= 180 && bytes_sent < 300);
            if ($urandom_range(0, 99) < 85) send_stream();
            else send_noise();
        end
        idle_ok = 1'b1;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d compressed bytes in, %0d result transactions checked",
                 bytes_accepted, results_checked);
        $display("run: %0d back references copied, %0d end markers, %0d mismatches",
                 copies_seen, markers_seen, mismatches);
        if (mismatches == 0) begin
            $display("** lzss_window_decompressor: PASSED **");
        end else begin
            $display("** lzss_window_decompressor: FAILED **");
        end
        $finish;
    end

endmodule
